// ===== rtl/core/ple_pkg.sv =====
// shared request codes, status codes and control types for the positional list engine
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic exec;     // insert, delete or empty read result
		logic rd_start; // clear read index
		logic emit;     // put one read element in the output register
	} ple_cmd_t;

	typedef struct packed {
		logic empty;    // list holds no entries
		logic rd_last;  // read index at final entry
		logic out_busy; // output register full and not taken
	} ple_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ple_ctrl.sv =====
// controller state machine for the positional list engine
`timescale 1ns / 1ps
`default_nettype none
module ple_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        req_type,
	input  wire ple_pkg::ple_stat_t stat,
	output ple_pkg::ple_cmd_t      cmd
);
	import ple_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;
	logic   is_rd;

	assign in_ready = (state_q == S_IDLE) && !stat.out_busy;
	assign accept   = in_valid && in_ready;
	assign is_rd    = (req_type != REQ_INSERT) && (req_type != REQ_DELETE);

	always_comb begin
		state_d      = state_q;
		cmd.exec     = 1'b0;
		cmd.rd_start = 1'b0;
		cmd.emit     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_rd && !stat.empty) begin
						cmd.rd_start = 1'b1;
						state_d      = S_READ;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			S_READ: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					if (stat.rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ple_dp.sv =====
// datapath: shifting entry cells, entry count, read index and output register
`timescale 1ns / 1ps
`default_nettype none
module ple_dp #(
	parameter int DEPTH = 16,
	parameter int CW    = $clog2(DEPTH + 1),
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         req_type,
	input  wire logic [CW-1:0]      position,
	input  wire logic signed [31:0] value,
	input  wire ple_pkg::ple_cmd_t  cmd,
	output ple_pkg::ple_stat_t      stat,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      value_res,
	output logic [CW-1:0]           count,
	output logic                    last
);
	import ple_pkg::*;

	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic signed [31:0] entries_q [DEPTH];
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      idx_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic signed [31:0] value_q;
	logic [CW-1:0]      cnt_res_q;
	logic               last_q;

	logic               do_ins, do_del;
	logic               ins_ok, del_ok;
	logic [IW-1:0]      rd_addr;
	logic signed [31:0] rd_data;

	assign ins_ok  = (position <= count_q) && (count_q != FULL_CNT);
	assign del_ok  = (count_q != '0) && (position < count_q);
	assign do_ins  = cmd.exec && (req_type == REQ_INSERT) && ins_ok;
	assign do_del  = cmd.exec && (req_type == REQ_DELETE) && del_ok;
	assign rd_addr = cmd.exec ? position[IW-1:0] : idx_q;
	assign rd_data = entries_q[rd_addr];

	assign stat.empty    = (count_q == '0);
	assign stat.rd_last  = (CW'(idx_q) == (count_q - 1'b1));
	assign stat.out_busy = out_valid_q && !out_ready;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (CW'(i) == position) begin
					entries_q[i] <= value;
				end else if (CW'(i) > position) begin
					if (i > 0) begin
						entries_q[i] <= entries_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (do_del) begin
				if ((CW'(i) >= position) && (i < DEPTH - 1)) begin
					entries_q[i] <= entries_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_ins) begin
				count_q <= count_q + 1'b1;
			end else if (do_del) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.rd_start) begin
				idx_q <= '0;
			end else if (cmd.emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.exec || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			last_q <= 1'b1;
			if (req_type == REQ_INSERT) begin
				value_q <= '0;
				if (position > count_q) begin
					status_q  <= ST_BADPOS;
					cnt_res_q <= count_q;
				end else if (count_q == FULL_CNT) begin
					status_q  <= ST_FULL;
					cnt_res_q <= count_q;
				end else begin
					status_q  <= ST_OK;
					cnt_res_q <= count_q + 1'b1;
				end
			end else if (req_type == REQ_DELETE) begin
				if (count_q == '0) begin
					status_q  <= ST_EMPTY;
					value_q   <= '0;
					cnt_res_q <= '0;
				end else if (position >= count_q) begin
					status_q  <= ST_BADPOS;
					value_q   <= '0;
					cnt_res_q <= count_q;
				end else begin
					status_q  <= ST_OK;
					value_q   <= rd_data;
					cnt_res_q <= count_q - 1'b1;
				end
			end else begin
				status_q  <= ST_EMPTY;
				value_q   <= '0;
				cnt_res_q <= '0;
			end
		end else if (cmd.emit) begin
			status_q  <= ST_OK;
			value_q   <= rd_data;
			cnt_res_q <= count_q;
			last_q    <= stat.rd_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value_res = value_q;
	assign count     = cnt_res_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
// top level of the positional list engine: controller plus datapath
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------
//  request | in_valid / in_ready | req_type, position, value
//  result  | out_valid/out_ready | status, value_res, count, last
//
// insert and delete: all cells shift at once
// read out: once the transaction is taken, one result per cycle while out_ready stays high, count results in all
// read out of an empty list: a single empty result
// a single output register sets the pace: a new transaction is taken once it is free and no read out is in progress
// reset clears the count and control state; entry cells are not cleared
// out_ready low holds the result and stalls the read stream
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine #(
	parameter int DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    req_type,
	input  wire logic [$clog2(DEPTH+1)-1:0]    position,
	input  wire logic signed [31:0]            value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         status,
	output logic signed [31:0]                 value_res,
	output logic [$clog2(DEPTH+1)-1:0]         count,
	output logic                               last
);
	import ple_pkg::*;

	ple_cmd_t  cmd;
	ple_stat_t stat;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd)
	);

	ple_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_type  (req_type),
		.position  (position),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.value_res (value_res),
		.count     (count),
		.last      (last)
	);

endmodule
`default_nettype wire

// ===== rtl/core/ple_checker.sv =====
// port-level assertions for the positional list engine and their bind
`timescale 1ns / 1ps
`default_nettype none
module ple_checker #(
	parameter int DEPTH = 16
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic [1:0]                 req_type,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [1:0]                 status,
	input wire logic signed [31:0]         value_res,
	input wire logic [$clog2(DEPTH+1)-1:0] count,
	input wire logic                       last
);
	import ple_pkg::*;

	// insert or delete transaction gives a single final result next cycle
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_INSERT || req_type == REQ_DELETE)
		|=> out_valid && last)
		else $error("insert or delete did not give a final result");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last)
		else $error("error result not marked last");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (count == '0))
		else $error("empty status with nonzero count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready
		|=> out_valid && $stable(value_res) && $stable(status) && $stable(last))
		else $error("stalled result changed");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.value_res (value_res),
	.count     (count),
	.last      (last)
);
`default_nettype wire

// ===== verif/positional_list_engine_test.sv =====
// self-checking testbench for positional_list_engine: queued requests, shadow list, result checker
`timescale 1ns / 1ps
module positional_list_engine_test;
	import ple_pkg::*;

	localparam int DEPTH = 16;
	localparam int PW = $clog2(DEPTH + 1);
	localparam int ITEMS = 260;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;

	// read codes not named in the package
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]        req;
		logic [PW-1:0]     pos;
		logic [31:0]       val;
		logic              drain_first;
	} list_request_t;

	typedef struct packed {
		logic [1:0]        status;
		logic signed [31:0] word;
		logic [PW-1:0]     cnt;
		logic              fin;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [1:0] req_type = REQ_INSERT;
	logic [PW-1:0] position = '0;
	logic signed [31:0] value = '0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic [1:0] status;
	logic signed [31:0] value_res;
	logic [PW-1:0] count;
	logic last;

	list_request_t request_q[$];
	list_result_t pending_results[$];
	logic signed [31:0] shadow_list[DEPTH];
	int shadow_len = 0;
	int gen_len = 0;

	int tx_gap = 0, tx_calm = 0, rx_hold = 0, rx_calm = 0, stall_cycles = 0;
	int mismatches = 0, results_seen = 0;
	int n_insert = 0, n_delete = 0, n_read = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	list_request_t next_req;
	list_result_t exp_res;

	positional_list_engine #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.value_res(value_res),
		.count(count),
		.last(last)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// shadow list update and expected results for one accepted transaction
	task automatic apply_list_request(input logic [1:0] rq, input logic [PW-1:0] ps,
			input logic signed [31:0] vl);
		list_result_t r;
		int p;
		p = int'(ps);
		r.word = '0;
		r.fin = 1'b1;
		if (rq == REQ_INSERT) begin
			if (p > shadow_len) begin
				r.status = ST_BADPOS;
			end else if (shadow_len >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				for (int i = shadow_len; i > p; i--)
					shadow_list[i] = shadow_list[i - 1];
				shadow_list[p] = vl;
				shadow_len++;
				r.status = ST_OK;
			end
			r.cnt = shadow_len[PW-1:0];
			pending_results.push_back(r);
		end else if (rq == REQ_DELETE) begin
			if (shadow_len == 0) begin
				r.status = ST_EMPTY;
			end else if (p >= shadow_len) begin
				r.status = ST_BADPOS;
			end else begin
				r.word = shadow_list[p];
				for (int i = p; i + 1 < shadow_len; i++)
					shadow_list[i] = shadow_list[i + 1];
				shadow_len--;
				r.status = ST_OK;
			end
			r.cnt = shadow_len[PW-1:0];
			pending_results.push_back(r);
		end else if (shadow_len == 0) begin
			r.status = ST_EMPTY;
			r.cnt = '0;
			pending_results.push_back(r);
		end else begin
			for (int i = 0; i < shadow_len; i++) begin
				r.status = ST_OK;
				r.word = shadow_list[i];
				r.cnt = shadow_len[PW-1:0];
				r.fin = (i + 1 == shadow_len);
				pending_results.push_back(r);
			end
		end
	endtask

	task automatic queue_request(input logic [1:0] rq, input int ps, input logic [31:0] vl,
			input bit drain);
		list_request_t item;
		item.req = rq;
		item.pos = ps[PW-1:0];
		item.val = vl;
		item.drain_first = drain;
		request_q.push_back(item);
		if (rq == REQ_INSERT && ps <= gen_len && gen_len < DEPTH)
			gen_len++;
		else if (rq == REQ_DELETE && ps < gen_len)
			gen_len--;
	endtask

	initial begin
		int mode, n, pick;
		bit drain_now, first_segment;
		// directed requests
		queue_request(REQ_READ, 0, 32'h0, 1'b0);
		queue_request(REQ_SPARE, 31, 32'hffffffff, 1'b0);
		queue_request(REQ_DELETE, 0, 32'h0, 1'b0);
		queue_request(REQ_INSERT, 1, 32'h12345678, 1'b0);
		queue_request(REQ_INSERT, 31, 32'h0, 1'b0);
		queue_request(REQ_INSERT, 0, 32'h7fffffff, 1'b0);
		queue_request(REQ_INSERT, 0, 32'h80000000, 1'b0);
		queue_request(REQ_INSERT, 2, 32'hffffffff, 1'b0);
		queue_request(REQ_INSERT, 1, 32'h00000000, 1'b0);
		queue_request(REQ_DELETE, 4, 32'h0, 1'b0);
		queue_request(REQ_READ, 0, 32'h0, 1'b1);
		queue_request(REQ_DELETE, 1, 32'h0, 1'b0);
		queue_request(REQ_DELETE, 2, 32'h0, 1'b0);
		queue_request(REQ_DELETE, 0, 32'h0, 1'b0);
		queue_request(REQ_INSERT, 1, 32'h55555555, 1'b0);
		queue_request(REQ_INSERT, 3, 32'haaaaaaaa, 1'b0);
		queue_request(REQ_DELETE, 16, 32'h0, 1'b0);
		queue_request(REQ_SPARE, 0, 32'h0, 1'b0);
		// random segments, the first one always fills the list
		first_segment = 1'b1;
		while (request_q.size() < ITEMS) begin
			mode = first_segment ? 6 : $urandom_range(0, 9);
			first_segment = 1'b0;
			drain_now = ($urandom_range(0, 9) == 0);
			if (mode < 6) begin
				n = $urandom_range(4, 12);
				repeat (n) begin
					pick = $urandom_range(0, 9);
					if (pick == 0)
						queue_request(REQ_READ, $urandom_range(0, 31), $urandom, drain_now);
					else if ((pick < 6 && gen_len < DEPTH) || gen_len == 0)
						queue_request(REQ_INSERT, $urandom_range(0, gen_len), $urandom,
							drain_now);
					else
						queue_request(REQ_DELETE, $urandom_range(0, gen_len - 1), $urandom,
							drain_now);
					drain_now = 1'b0;
				end
			end else if (mode < 8) begin
				while (gen_len < DEPTH) begin
					queue_request(REQ_INSERT, $urandom_range(0, gen_len), $urandom, drain_now);
					drain_now = 1'b0;
				end
				queue_request(REQ_INSERT, $urandom_range(0, DEPTH), $urandom, 1'b0);
				queue_request(REQ_INSERT, $urandom_range(DEPTH + 1, 31), $urandom, 1'b0);
				queue_request(REQ_DELETE, $urandom_range(DEPTH, 31), $urandom, 1'b0);
				queue_request(REQ_READ, 0, $urandom, 1'b0);
			end else if (mode == 8) begin
				while (gen_len > 0) begin
					queue_request(REQ_DELETE, $urandom_range(0, gen_len - 1), $urandom,
						drain_now);
					drain_now = 1'b0;
				end
				queue_request(REQ_DELETE, $urandom_range(0, 31), $urandom, 1'b0);
				queue_request(REQ_INSERT, $urandom_range(1, 31), $urandom, 1'b0);
				queue_request(REQ_READ, 0, $urandom, 1'b0);
			end else begin
				n = $urandom_range(3, 6);
				repeat (n)
					queue_request(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom,
						1'b0);
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_INSERT;
			position <= '0;
			value <= '0;
		end else begin
			if (in_valid && in_ready) begin
				apply_list_request(req_type, position, value);
				if (req_type == REQ_INSERT)
					n_insert++;
				else if (req_type == REQ_DELETE)
					n_delete++;
				else
					n_read++;
			end
			if (!(in_valid && !in_ready)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (request_q.size() != 0 &&
						(!request_q[0].drain_first || pending_results.size() == 0)) begin
					next_req = request_q.pop_front();
					req_type <= next_req.req;
					position <= next_req.pos;
					value <= next_req.val;
					in_valid <= 1'b1;
					if (tx_calm > 0) begin
						tx_calm--;
						tx_gap = 0;
					end else begin
						tx_gap = pick_gap();
						if ($urandom_range(0, 24) == 0)
							tx_calm = $urandom_range(15, 40);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				status_seen[status]++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: st=%0d val=%0d cnt=%0d last=%0d",
							status, value_res, count, last);
				end else begin
					exp_res = pending_results.pop_front();
					if (status !== exp_res.status || value_res !== exp_res.word ||
							count !== exp_res.cnt || last !== exp_res.fin) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch on result %0d: expected st=%0d val=%0d cnt=%0d last=%0d",
								results_seen, exp_res.status, exp_res.word, exp_res.cnt,
								exp_res.fin);
							$display("  got st=%0d val=%0d cnt=%0d last=%0d",
								status, value_res, count, last);
						end
					end
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				if (rx_calm > 0) begin
					rx_calm--;
					rx_hold = 0;
				end else begin
					rx_hold = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
					if ($urandom_range(0, 29) == 0)
						rx_calm = $urandom_range(15, 40);
				end
				out_ready <= (rx_hold == 0);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout with %0d requests queued and %0d results outstanding",
					request_q.size(), pending_results.size());
				$display("positional_list_engine verification failed");
				$finish;
			end
		end
	end

	initial begin
		wait (arst_n);
		@(negedge clk);
		while (request_q.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d requests (%0d inserts, %0d deletes, %0d read-outs), %0d results",
			n_insert + n_delete + n_read, n_insert, n_delete, n_read, results_seen);
		$display("status mix: ok %0d, bad position %0d, full %0d, empty %0d; mismatches %0d",
			status_seen[ST_OK], status_seen[ST_BADPOS], status_seen[ST_FULL],
			status_seen[ST_EMPTY], mismatches);
		if (mismatches == 0)
			$display("positional_list_engine verification clean");
		else
			$display("positional_list_engine verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ple_pkg.sv
rtl/core/ple_ctrl.sv
rtl/core/ple_dp.sv
rtl/core/positional_list_engine.sv
rtl/core/ple_checker.sv
verif/positional_list_engine_test.sv
